[design/gbn_pkg.sv]
// Shared types and constants for the go-back-N sender window.
// No dependencies; imported by every other design file.
package gbn_pkg;

  localparam int WINDOW       = 4;
  localparam int SEQ_SPACE    = 8;   // power of two: sequence arithmetic wraps naturally
  localparam int PAYLOAD_BITS = 64;

  localparam int SEQ_W = $clog2(SEQ_SPACE);
  localparam int CNT_W = $clog2(WINDOW + 1);

  typedef logic [SEQ_W-1:0]        seq_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [PAYLOAD_BITS-1:0] data_t;

  // input kinds
  localparam logic [1:0] MODE_SEND    = 2'd0;
  localparam logic [1:0] MODE_ACK     = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;

  // result kinds
  localparam logic [1:0] EV_REFUSED = 2'd0;
  localparam logic [1:0] EV_NEW     = 2'd1;
  localparam logic [1:0] EV_TIMER   = 2'd2;
  localparam logic [1:0] EV_RETX    = 2'd3;

  // timer actions
  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;
  localparam logic [1:0] TMR_RESTART = 2'd3;

  typedef struct packed {
    logic [1:0] event_res;
    seq_t       seq_num;
    data_t      packet_data;
    logic [1:0] timer_action;
    seq_t       timer_stop_seq;
    seq_t       timer_start_seq;
    logic       window_full;
    logic       last;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;    // input word accepted this cycle
    logic fetch;   // read next replay entry from the store
    logic emit;    // load fetched replay entry into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;     // output register free or being emptied this cycle
    logic start_replay;  // presented word is a timeout with packets outstanding
    logic last_replay;   // current replay entry is the final one
  } sts_t;

endpackage

[design/gbn_in_if.sv]
// Input channel of the go-back-N sender: valid/ready plus request fields.
// Depends on gbn_pkg.
interface gbn_in_if;
  import gbn_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  data_t      payload;
  seq_t       ack_num;
  logic       ack_intact;
  seq_t       expired_seq;

  modport source (output valid, mode, payload, ack_num, ack_intact, expired_seq,
                  input ready);
  modport sink   (input valid, mode, payload, ack_num, ack_intact, expired_seq,
                  output ready);
endinterface

[design/gbn_out_if.sv]
// Result channel of the go-back-N sender: valid/ready plus result fields.
// Depends on gbn_pkg.
interface gbn_out_if;
  import gbn_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  seq_t       seq_num;
  data_t      packet_data;
  logic [1:0] timer_action;
  seq_t       timer_stop_seq;
  seq_t       timer_start_seq;
  logic       window_full;
  logic       last;

  modport source (output valid, event_res, seq_num, packet_data, timer_action,
                  timer_stop_seq, timer_start_seq, window_full, last,
                  input ready);
  modport sink   (input valid, event_res, seq_num, packet_data, timer_action,
                  timer_stop_seq, timer_start_seq, window_full, last,
                  output ready);
endinterface

[design/gbn_ctrl.sv]
// Controller FSM: input handshake and sequencing of timeout replays.
// Depends on gbn_pkg.
module gbn_ctrl
  import gbn_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = sts.slot_free;
        cmd.take = in_valid && sts.slot_free;
        if (cmd.take && sts.start_replay) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last_replay ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[design/gbn_dp.sv]
// Datapath: window registers, packet store, replay index and output register.
// Depends on gbn_pkg; driven by gbn_ctrl commands.
module gbn_dp
  import gbn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic [1:0] in_mode,
  input  data_t      in_payload,
  input  seq_t       in_ack_num,
  input  logic       in_ack_intact,
  input  seq_t       in_expired_seq,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res
);

  seq_t  base_r, base_nxt;
  seq_t  next_seq_r, next_seq_nxt;
  cnt_t  cnt_r, cnt_nxt;
  logic  waiting_r, waiting_nxt;
  cnt_t  idx_r, idx_nxt;
  seq_t  exp_r, exp_nxt;
  logic  out_valid_r, out_valid_nxt;
  res_t  out_r, out_nxt;
  data_t mem_q_r;
  data_t store [SEQ_SPACE];

  logic  mem_we;
  seq_t  rd_addr;
  seq_t  ack_off;
  cnt_t  cnt_after_ack;
  cnt_t  cnt_inc;
  logic  load;

  assign rd_addr       = seq_t'(base_r + seq_t'(idx_r));
  assign ack_off       = seq_t'(in_ack_num - base_r);
  assign cnt_after_ack = cnt_t'(cnt_r - cnt_t'(ack_off) - cnt_t'(1));
  assign cnt_inc       = cnt_t'(cnt_r + cnt_t'(1));

  assign sts.slot_free    = !out_valid_r || out_ready;
  assign sts.start_replay = (in_mode == MODE_TIMEOUT) && (cnt_r != '0);
  assign sts.last_replay  = (cnt_t'(idx_r + cnt_t'(1)) == cnt_r);

  always_comb begin
    base_nxt     = base_r;
    next_seq_nxt = next_seq_r;
    cnt_nxt      = cnt_r;
    waiting_nxt  = waiting_r;
    idx_nxt      = idx_r;
    exp_nxt      = exp_r;
    out_nxt      = out_r;
    load         = 1'b0;
    mem_we       = 1'b0;
    if (cmd.take) begin
      case (in_mode)
        MODE_SEND: begin
          load    = 1'b1;
          out_nxt = '0;
          out_nxt.last = 1'b1;
          if (cnt_r >= cnt_t'(WINDOW)) begin
            waiting_nxt           = 1'b1;
            out_nxt.event_res     = EV_REFUSED;
            out_nxt.window_full   = 1'b1;
          end else begin
            mem_we                = 1'b1;
            cnt_nxt               = cnt_inc;
            next_seq_nxt          = seq_t'(next_seq_r + seq_t'(1));
            waiting_nxt           = (cnt_inc >= cnt_t'(WINDOW));
            out_nxt.event_res     = EV_NEW;
            out_nxt.seq_num       = next_seq_r;
            out_nxt.packet_data   = in_payload;
            out_nxt.window_full   = (cnt_inc >= cnt_t'(WINDOW));
            if (cnt_r == '0) begin
              out_nxt.timer_action    = TMR_START;
              out_nxt.timer_start_seq = next_seq_r;
            end
          end
        end
        MODE_ACK: begin
          if (in_ack_intact && (ack_off < seq_t'(cnt_r))) begin
            load                   = 1'b1;
            cnt_nxt                = cnt_after_ack;
            base_nxt               = seq_t'(in_ack_num + seq_t'(1));
            waiting_nxt            = 1'b0;
            out_nxt                = '0;
            out_nxt.last           = 1'b1;
            out_nxt.event_res      = EV_TIMER;
            out_nxt.timer_stop_seq = base_r;
            if (cnt_after_ack == '0) begin
              out_nxt.timer_action = TMR_STOP;
            end else begin
              out_nxt.timer_action    = TMR_RESTART;
              out_nxt.timer_start_seq = seq_t'(in_ack_num + seq_t'(1));
            end
          end
        end
        MODE_TIMEOUT: begin
          if (cnt_r == '0) begin
            load                   = 1'b1;
            out_nxt                = '0;
            out_nxt.last           = 1'b1;
            out_nxt.event_res      = EV_TIMER;
            out_nxt.timer_action   = TMR_STOP;
            out_nxt.timer_stop_seq = in_expired_seq;
            out_nxt.window_full    = waiting_r;
          end else begin
            idx_nxt = '0;
            exp_nxt = in_expired_seq;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.emit) begin
      load                = 1'b1;
      out_nxt             = '0;
      out_nxt.event_res   = EV_RETX;
      out_nxt.seq_num     = rd_addr;
      out_nxt.packet_data = mem_q_r;
      out_nxt.window_full = waiting_r;
      out_nxt.last        = sts.last_replay;
      if (idx_r == '0) begin
        out_nxt.timer_action    = TMR_RESTART;
        out_nxt.timer_stop_seq  = exp_r;
        out_nxt.timer_start_seq = base_r;
      end
      idx_nxt = cnt_t'(idx_r + cnt_t'(1));
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= seq_t'(1);
      next_seq_r  <= seq_t'(1);
      cnt_r       <= '0;
      waiting_r   <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      next_seq_r  <= next_seq_nxt;
      cnt_r       <= cnt_nxt;
      waiting_r   <= waiting_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    exp_r <= exp_nxt;
    out_r <= out_nxt;
  end

  // packet store: one write port (send), one registered read port (replay)
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[next_seq_r] <= in_payload;
    end
    if (cmd.fetch) begin
      mem_q_r <= store[rd_addr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(WINDOW))
    else $error("outstanding count above window");

  a_wait_full: assert property (@(posedge clk) disable iff (!rst_n)
    waiting_r == (cnt_r >= cnt_t'(WINDOW)))
    else $error("waiting flag out of step with count");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.slot_free)
    else $error("replay word emitted over an unread result");

  a_emit_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (out_valid_r && out_r.event_res == EV_RETX))
    else $error("replay word not presented");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.take && (cmd.fetch || cmd.emit)))
    else $error("new word taken during replay");

endmodule

[design/go_back_n_sender.sv]
// Top level of the go-back-N sender window: controller plus datapath.
// Depends on gbn_pkg, gbn_in_if, gbn_out_if, gbn_ctrl and gbn_dp.
//
//  channel | dir | handshake           | word
//  in_ch   | in  | valid/ready         | mode, payload, ack_num, ack_intact, expired_seq
//  out_ch  | out | valid/ready         | event_res, seq_num, packet_data, timer_action,
//          |     |                     | timer_stop_seq, timer_start_seq, window_full, last
//
// Sends, acks, empty-window timeouts and dropped words need no replay; any result
// is registered the cycle after acceptance, and a new word can be taken every cycle
// while the result register drains.
// Timeout with packets outstanding: after the accepting cycle, each replayed word
// takes a store read, then a load of the output register that waits while out_ch
// is stalled; no input word is taken meanwhile.
// Reset (rst_n low, synchronous): window base and next sequence 1, nothing
// outstanding, output empty. The packet store is not cleared.
// A stalled out_ch holds the current result and blocks in_ch until it drains.
module go_back_n_sender
  import gbn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  gbn_in_if.sink     in_ch,
  gbn_out_if.source  out_ch
);

  cmd_t  cmd;
  sts_t  sts;
  res_t  res;
  logic  ready;

  // handshake and replay sequencing
  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // window state, packet store and result register
  gbn_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_ch.mode),
    .in_payload     (in_ch.payload),
    .in_ack_num     (in_ch.ack_num),
    .in_ack_intact  (in_ch.ack_intact),
    .in_expired_seq (in_ch.expired_seq),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_res        (res)
  );

  assign in_ch.ready            = ready;
  assign out_ch.event_res       = res.event_res;
  assign out_ch.seq_num         = res.seq_num;
  assign out_ch.packet_data     = res.packet_data;
  assign out_ch.timer_action    = res.timer_action;
  assign out_ch.timer_stop_seq  = res.timer_stop_seq;
  assign out_ch.timer_start_seq = res.timer_start_seq;
  assign out_ch.window_full     = res.window_full;
  assign out_ch.last            = res.last;

endmodule
